@@ rtl/nprb_pkg.sv @@
package nprb_pkg;

  localparam int unsigned PAGE_BYTES  = 2048;
  localparam int unsigned BLOCK_BYTES = 131072;
  localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);

  localparam logic [31:0] PAGE_MASK   = 32'(PAGE_BYTES - 1);
  localparam logic [31:0] BLOCK_MASK  = 32'(BLOCK_BYTES - 1);
  localparam logic [31:0] MARKER_COL  = 32'(PAGE_BYTES);
  localparam logic [31:0] BLOCK_STEP  = 32'(BLOCK_BYTES);

  localparam logic [7:0] CMD_READ    = 8'h00;
  localparam logic [7:0] CMD_CONFIRM = 8'h30;
  localparam logic [7:0] GOOD_MARK   = 8'hFF;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_READY = 2'd1;
  localparam logic [1:0] FUNC_DATA  = 2'd2;

  typedef enum logic [2:0] {
    OP_SELECT   = 3'd0,
    OP_CMD      = 3'd1,
    OP_ADDR     = 3'd2,
    OP_WAIT     = 3'd3,
    OP_STROBE   = 3'd4,
    OP_DESELECT = 3'd5,
    OP_STORE    = 3'd6,
    OP_DONE     = 3'd7
  } op_e_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BAD_READY,
    MODE_BAD_MARK,
    MODE_PAGE_READY,
    MODE_PAGE_DATA
  } mode_t;

  // result slots in emission order
  typedef enum logic [3:0] {
    ST_STORE,
    ST_STROBE,
    ST_DESEL,
    ST_DONE,
    ST_SELECT,
    ST_CMD_READ,
    ST_COL_LO,
    ST_COL_HI,
    ST_PAGE_0,
    ST_PAGE_1,
    ST_PAGE_2,
    ST_CMD_CONFIRM,
    ST_WAIT
  } step_t;

  localparam int unsigned NUM_STEPS = 13;

  typedef logic [NUM_STEPS-1:0] step_mask_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] start_addr;
    logic [31:0] length;
    logic [7:0]  flash_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  value;
    logic [31:0] dest_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    step_mask_t  mask;
    logic [7:0]  store_byte;
    logic [31:0] store_index;
    logic [7:0]  col_lo;
    logic [7:0]  col_hi;
    logic [7:0]  page_0;
    logic [7:0]  page_1;
    logic [7:0]  page_2;
  } plan_t;

endpackage

@@ rtl/nprb_seq.sv @@
module nprb_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nprb_pkg::in_item_t in_data,
  output logic              plan_valid,
  output nprb_pkg::plan_t   plan,
  input  logic              plan_ready
);
  import nprb_pkg::*;

  logic        in_v_r;
  in_item_t    in_r;
  logic        take;

  mode_t       mode_r, mode_nxt;
  logic [31:0] fa_r, fa_nxt;
  logic [31:0] done_r, done_nxt;
  logic [31:0] wanted_r, wanted_nxt;

  logic        do_adv, do_page, do_mark;
  logic [31:0] col_w, page_w;

  assign in_ready   = !in_v_r || plan_ready;
  assign take       = in_v_r && plan_ready;
  assign plan_valid = in_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      fa_r     <= '0;
      done_r   <= '0;
      wanted_r <= '0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      fa_r     <= fa_nxt;
      done_r   <= done_nxt;
      wanted_r <= wanted_nxt;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    fa_nxt     = fa_r;
    done_nxt   = done_r;
    wanted_nxt = wanted_r;
    plan       = '0;
    do_adv     = 1'b0;
    do_page    = 1'b0;
    do_mark    = 1'b0;
    plan.store_byte  = in_r.flash_byte;
    plan.store_index = done_r;

    case (in_r.func)
      FUNC_START: begin
        fa_nxt     = in_r.start_addr;
        wanted_nxt = in_r.length;
        done_nxt   = '0;
        do_adv     = 1'b1;
      end
      FUNC_READY: begin
        unique case (mode_r)
          MODE_BAD_READY: begin
            plan.mask[ST_STROBE] = 1'b1;
            mode_nxt = MODE_BAD_MARK;
          end
          MODE_PAGE_READY: begin
            plan.mask[ST_STROBE] = 1'b1;
            mode_nxt = MODE_PAGE_DATA;
          end
          default: ;
        endcase
      end
      FUNC_DATA: begin
        unique case (mode_r)
          MODE_BAD_MARK: begin
            plan.mask[ST_DESEL] = 1'b1;
            if (in_r.flash_byte != GOOD_MARK) begin
              fa_nxt = fa_r + BLOCK_STEP;
              do_adv = 1'b1;
            end else begin
              do_page = 1'b1;
            end
          end
          MODE_PAGE_DATA: begin
            plan.mask[ST_STORE] = 1'b1;
            done_nxt = done_r + 32'd1;
            fa_nxt   = fa_r + 32'd1;
            // keep streaming while inside the page and short of the count
            if (((fa_nxt & PAGE_MASK) != '0) && (done_nxt < wanted_r)) begin
              plan.mask[ST_STROBE] = 1'b1;
            end else begin
              plan.mask[ST_DESEL] = 1'b1;
              do_adv = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (do_adv) begin
      if (done_nxt >= wanted_nxt) begin
        plan.mask[ST_DONE] = 1'b1;
        mode_nxt = MODE_IDLE;
      end else if ((fa_nxt & BLOCK_MASK) == '0) begin
        do_mark = 1'b1;
      end else begin
        do_page = 1'b1;
      end
    end

    col_w  = do_mark ? MARKER_COL : (fa_nxt & PAGE_MASK);
    page_w = fa_nxt >> PAGE_SHIFT;

    if (do_mark || do_page) begin
      plan.mask[ST_SELECT]      = 1'b1;
      plan.mask[ST_CMD_READ]    = 1'b1;
      plan.mask[ST_COL_LO]      = 1'b1;
      plan.mask[ST_COL_HI]      = 1'b1;
      plan.mask[ST_PAGE_0]      = 1'b1;
      plan.mask[ST_PAGE_1]      = 1'b1;
      plan.mask[ST_PAGE_2]      = 1'b1;
      plan.mask[ST_CMD_CONFIRM] = 1'b1;
      plan.mask[ST_WAIT]        = 1'b1;
      mode_nxt = do_mark ? MODE_BAD_READY : MODE_PAGE_READY;
    end
    plan.col_lo = col_w[7:0];
    plan.col_hi = col_w[15:8];
    plan.page_0 = page_w[7:0];
    plan.page_1 = page_w[15:8];
    plan.page_2 = page_w[23:16];
  end

endmodule

@@ rtl/nprb_emit.sv @@
module nprb_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               plan_valid,
  input  nprb_pkg::plan_t    plan,
  output logic               plan_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output nprb_pkg::out_item_t out_data
);
  import nprb_pkg::*;

  step_mask_t mask_r, mask_nxt;
  plan_t      plan_r;
  step_t      sel;
  step_mask_t remaining;

  assign out_valid  = (mask_r != '0);
  assign remaining  = mask_r & ~(step_mask_t'(1) << sel);
  assign plan_ready = !out_valid || (out_ready && (remaining == '0));

  // lowest pending slot goes out first
  always_comb begin
    sel = ST_STORE;
    for (int i = NUM_STEPS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = step_t'(4'(i));
      end
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (plan_valid && plan_ready) begin
      mask_nxt = plan.mask;
    end else if (out_valid && out_ready) begin
      mask_nxt = remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
    if (plan_valid && plan_ready) begin
      plan_r <= plan;
    end
  end

  always_comb begin
    out_data            = '0;
    out_data.last       = (remaining == '0);
    unique case (sel)
      ST_STORE: begin
        out_data.op         = OP_STORE;
        out_data.value      = plan_r.store_byte;
        out_data.dest_index = plan_r.store_index;
      end
      ST_STROBE:      out_data.op = OP_STROBE;
      ST_DESEL:       out_data.op = OP_DESELECT;
      ST_DONE:        out_data.op = OP_DONE;
      ST_SELECT:      out_data.op = OP_SELECT;
      ST_CMD_READ: begin
        out_data.op    = OP_CMD;
        out_data.value = CMD_READ;
      end
      ST_COL_LO: begin
        out_data.op    = OP_ADDR;
        out_data.value = plan_r.col_lo;
      end
      ST_COL_HI: begin
        out_data.op    = OP_ADDR;
        out_data.value = plan_r.col_hi;
      end
      ST_PAGE_0: begin
        out_data.op    = OP_ADDR;
        out_data.value = plan_r.page_0;
      end
      ST_PAGE_1: begin
        out_data.op    = OP_ADDR;
        out_data.value = plan_r.page_1;
      end
      ST_PAGE_2: begin
        out_data.op    = OP_ADDR;
        out_data.value = plan_r.page_2;
      end
      ST_CMD_CONFIRM: begin
        out_data.op    = OP_CMD;
        out_data.value = CMD_CONFIRM;
      end
      ST_WAIT:        out_data.op = OP_WAIT;
      default:        out_data.op = OP_DONE;
    endcase
  end

endmodule

@@ rtl/nand_page_read_bad_block_skip.sv @@
// NAND page copy sequencer with bad-block skipping.
// in_ channel (valid/ready): one request per transfer: func 0 starts a copy at
// start_addr for length bytes, func 1 reports flash ready, func 2 hands in a
// byte read from the flash data port. Other requests are dropped quietly.
// out_ channel (valid/ready): flash bus operations and byte stores, one per
// transfer; last marks the final result of one request.
// A request is held in the input register while its results are planned, then
// the plan is loaded into the result register, from which the results are
// offered. Results go out one per cycle while out_ready is high. A request
// yields at most 11 results; the next request is taken while the final result
// of the previous one is being accepted, so data bytes that yield store plus
// strobe stream without a gap, and requests with one or no result go back to
// back.
// Reset (rst_n low, synchronous) returns to idle with address and counters at
// zero and both registers empty. When out_ready is low the result holds and
// the input side fills its one register, then drops in_ready.
module nand_page_read_bad_block_skip (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nprb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nprb_pkg::out_item_t out_data
);
  import nprb_pkg::*;

  logic  plan_valid;
  logic  plan_ready;
  plan_t plan;

  nprb_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .plan_valid (plan_valid),
    .plan       (plan),
    .plan_ready (plan_ready)
  );

  nprb_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan_valid (plan_valid),
    .plan       (plan),
    .plan_ready (plan_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // an empty result register always takes the next plan
  a_idle_takes_plan: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> plan_ready)
    else $error("result register empty but not taking a plan");

  // done is always the final result of its request
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.op == OP_DONE) |-> out_data.last)
    else $error("done not flagged last");

  // a burst keeps going until its last result is taken
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("result burst broken before last");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import nprb_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_REQUESTS = 63;

  // tracks the copy sequencer and keeps the flash bus operations still owed
  class copy_scoreboard;
    mode_t       mode;
    logic [31:0] flash_addr;
    logic [11:0] column;
    logic [31:0] copied;
    logic [31:0] wanted;
    out_item_t   bus_ops[$];
    out_item_t   step_ops[$];
    int          errors;

    function new();
      mode = MODE_IDLE;
      flash_addr = '0;
      column = '0;
      copied = '0;
      wanted = '0;
      errors = 0;
    endfunction

    function void put(op_e_t op, logic [7:0] value, logic [31:0] index);
      out_item_t r;
      r.op = op;
      r.value = value;
      r.dest_index = index;
      r.last = 1'b0;
      step_ops.push_back(r);
    endfunction

    // select, read command, column, page, confirm, wait
    function void send_address(logic [11:0] col, mode_t next_mode);
      logic [31:0] page;
      page = flash_addr >> PAGE_SHIFT;
      put(OP_SELECT, 8'h00, '0);
      put(OP_CMD, CMD_READ, '0);
      put(OP_ADDR, col[7:0], '0);
      put(OP_ADDR, 8'(col >> 8), '0);
      put(OP_ADDR, page[7:0], '0);
      put(OP_ADDR, page[15:8], '0);
      put(OP_ADDR, page[23:16], '0);
      put(OP_CMD, CMD_CONFIRM, '0);
      put(OP_WAIT, 8'h00, '0);
      mode = next_mode;
    endfunction

    function void continue_copy();
      if (copied >= wanted) begin
        put(OP_DONE, 8'h00, '0);
        mode = MODE_IDLE;
      end else if ((flash_addr & BLOCK_MASK) == '0) begin
        send_address(MARKER_COL[11:0], MODE_BAD_READY);
      end else begin
        column = 12'(flash_addr & PAGE_MASK);
        send_address(column, MODE_PAGE_READY);
      end
    endfunction

    function int note_request(in_item_t req);
      out_item_t r;
      step_ops.delete();
      case (req.func)
        FUNC_START: begin
          flash_addr = req.start_addr;
          wanted = req.length;
          copied = '0;
          column = 12'(flash_addr & PAGE_MASK);
          continue_copy();
        end
        FUNC_READY: begin
          if (mode == MODE_BAD_READY || mode == MODE_PAGE_READY) begin
            put(OP_STROBE, 8'h00, '0);
            mode = (mode == MODE_BAD_READY) ? MODE_BAD_MARK : MODE_PAGE_DATA;
          end
        end
        FUNC_DATA: begin
          if (mode == MODE_BAD_MARK) begin
            put(OP_DESELECT, 8'h00, '0);
            if (req.flash_byte != GOOD_MARK) begin
              // bad block: skip it whole, address wraps
              flash_addr += BLOCK_STEP;
              column = 12'(flash_addr & PAGE_MASK);
              continue_copy();
            end else begin
              column = 12'(flash_addr & PAGE_MASK);
              send_address(column, MODE_PAGE_READY);
            end
          end else if (mode == MODE_PAGE_DATA) begin
            put(OP_STORE, req.flash_byte, copied);
            copied++;
            flash_addr++;
            column++;
            if (column < PAGE_BYTES && copied < wanted) begin
              put(OP_STROBE, 8'h00, '0);
            end else begin
              column = 12'(flash_addr & PAGE_MASK);
              put(OP_DESELECT, 8'h00, '0);
              continue_copy();
            end
          end
        end
        default: ;
      endcase
      foreach (step_ops[i]) begin
        r = step_ops[i];
        r.last = (i == step_ops.size() - 1);
        bus_ops.push_back(r);
      end
      return step_ops.size();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (bus_ops.size() == 0) begin
        $display("%0t: no result expected, got op %0d value %h index %h last %b",
                 $time, got.op, got.value, got.dest_index, got.last);
        errors++;
      end else begin
        want = bus_ops.pop_front();
        if (got.op !== want.op || got.value !== want.value ||
            got.dest_index !== want.dest_index || got.last !== want.last) begin
          $display("%0t: expected op %0d value %h index %h last %b,", $time,
                   want.op, want.value, want.dest_index, want.last,
                   " got op %0d value %h index %h last %b",
                   got.op, got.value, got.dest_index, got.last);
          errors++;
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  copy_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;

  always #5 clk = ~clk;

  nand_page_read_bad_block_skip i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_data);
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        // long hold-off so the block backs up into its input
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic in_item_t make_request(logic [1:0] func, logic [31:0] addr,
                                            logic [31:0] len, logic [7:0] data);
    in_item_t it;
    it.func = func;
    it.start_addr = addr;
    it.length = len;
    it.flash_byte = data;
    return it;
  endfunction

  function automatic in_item_t start_request();
    in_item_t    it;
    logic [31:0] base;
    base = $urandom;
    it.func = FUNC_START;
    it.flash_byte = 8'($urandom);
    case ($urandom_range(4))
      0: it.start_addr = base;
      1: it.start_addr = base & ~BLOCK_MASK;
      2: it.start_addr = (base | PAGE_MASK) - $urandom_range(12);
      3: it.start_addr = (base | BLOCK_MASK) - $urandom_range(12);
      default: it.start_addr = 32'hFFFF_FFFF - $urandom_range(BLOCK_BYTES);
    endcase
    case ($urandom_range(19))
      0: it.length = '0;
      1, 2: it.length = $urandom;
      3, 4, 5, 6, 7, 8, 9, 10, 11: it.length = $urandom_range(8, 1);
      default: it.length = $urandom_range(60, 9);
    endcase
    return it;
  endfunction

  // mostly what the sequencer waits for, some noise and restarts
  function automatic in_item_t next_request();
    in_item_t it;
    it.func = FUNC_DATA;
    it.start_addr = $urandom;
    it.length = $urandom;
    it.flash_byte = 8'($urandom);
    if ($urandom_range(99) < 8) begin
      it.func = 2'($urandom_range(3));
    end else begin
      case (sb.mode)
        MODE_IDLE: it = start_request();
        MODE_BAD_READY, MODE_PAGE_READY: it.func = FUNC_READY;
        MODE_BAD_MARK: if ($urandom_range(99) < 65) it.flash_byte = GOOD_MARK;
        default: if ($urandom_range(99) < 2) it = start_request();
      endcase
    end
    return it;
  endfunction

  task automatic offer(in_item_t it, output int n);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    n = sb.note_request(it);
  endtask

  task automatic run_phase(int sender_idle, int receiver_stall, int count);
    int n;
    int answered;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    answered = 0;
    while (answered < count) begin
      offer(next_request(), n);
      if (n > 0)
        answered++;
    end
  endtask

  initial begin
    int n;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ignored codes and events while idle
    offer(make_request(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF), n);
    offer(make_request(FUNC_READY, '0, '0, 8'h00), n);
    offer(make_request(FUNC_DATA, '0, '0, 8'h00), n);
    // zero length answers done only
    offer(make_request(FUNC_START, '0, '0, 8'h00), n);
    // bad block at 0, good block next, two bytes
    offer(make_request(FUNC_START, '0, 32'd2, 8'h00), n);
    offer(make_request(FUNC_DATA, '0, '0, 8'h00), n);
    offer(make_request(FUNC_READY, '0, '0, 8'h00), n);
    offer(make_request(FUNC_READY, '0, '0, 8'h00), n);
    offer(make_request(FUNC_DATA, '0, '0, 8'h00), n);
    offer(make_request(FUNC_READY, '0, '0, 8'h00), n);
    offer(make_request(FUNC_DATA, '0, '0, GOOD_MARK), n);
    offer(make_request(FUNC_READY, '0, '0, 8'h00), n);
    offer(make_request(FUNC_DATA, '0, '0, 8'hFF), n);
    offer(make_request(FUNC_DATA, '0, '0, 8'h00), n);
    // top of the address space, wraps into a marker check at zero
    offer(make_request(FUNC_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00), n);
    offer(make_request(FUNC_READY, '0, '0, 8'h00), n);
    offer(make_request(FUNC_DATA, '0, '0, 8'hA5), n);
    offer(make_request(FUNC_READY, '0, '0, 8'h00), n);
    offer(make_request(FUNC_DATA, '0, '0, 8'h5A), n);
    // restart while busy, last byte of a page
    offer(make_request(FUNC_START, 32'h0000_07FF, 32'd1, 8'h00), n);
    offer(make_request(FUNC_READY, '0, '0, 8'h00), n);
    offer(make_request(FUNC_DATA, '0, '0, 8'h3C), n);

    run_phase(0, 0, PHASE_REQUESTS);
    run_phase(86, 0, PHASE_REQUESTS);
    run_phase(0, 86, PHASE_REQUESTS);
    run_phase(25, 25, PHASE_REQUESTS);
    holds_asked++;
    run_phase(0, 0, PHASE_REQUESTS);

    in_valid <= 1'b0;
    while (sb.bus_ops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
